// ----- design/prrb_pkg.sv -----
package prrb_pkg;

	localparam int BUF_DEPTH = 32;
	localparam int IDX_W     = $clog2(BUF_DEPTH);
	localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
	localparam int WIN_W     = 6;
	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(32);

	typedef enum logic [1:0] {
		RS_ACCEPTED  = 2'd0,
		RS_DROPPED   = 2'd1,
		RS_DUPLICATE = 2'd2,
		RS_BUFFERED  = 2'd3
	} res_status_t;

	typedef struct packed {
		logic [31:0] seq;
		logic        syn_flag;
		logic        data_flag;
		logic        has_data;
		logic [31:0] payload;
	} pkt_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        deliver_valid;
		logic [31:0] deliver_seq;
		logic [31:0] payload_out;
		logic        ack_send;
		logic [31:0] ack_number;
		logic        last;
	} res_t;

	// one reorder slot as held in the RAM
	typedef struct packed {
		logic [31:0] seq;
		logic        has_data;
		logic [31:0] payload;
	} slot_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_SCAN,
		S_FIRST,
		S_DRAIN
	} state_t;

	typedef struct packed {
		logic capture;
		logic eval_load;
		logic scan_init;
		logic scan_step;
		logic scan_done;
		logic first_load;
		logic drain_load;
	} cmd_t;

	typedef struct packed {
		logic in_order;
		logic out_free;
		logic scan_more;
		logic cnt_zero;
		logic cnt_one;
	} stat_t;

	// BUF_DEPTH is a power of two, so this is a mask
	function automatic logic [IDX_W-1:0] slot_idx(input logic [31:0] s);
		logic [31:0] r;
		r = s % BUF_DEPTH;
		return r[IDX_W-1:0];
	endfunction

endpackage

// ----- design/packet_receive_reorder_buffer_unit.sv -----
// Packet receive reorder buffer.
// Dropped, duplicate, buffered or non-DATA packets: one result, registered from the EVAL
// state once the output is free; a new packet is taken only after the return to IDLE.
// In-order DATA with n stored successors: chain walk through the slot RAM read port,
// then n+1 results one per cycle while results are taken.
// Reset: expected number 0, window 32, all slot valid bits cleared; no clearing pass.
module packet_receive_reorder_buffer_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pkt_valid,
	output logic                       pkt_ready,
	input  prrb_pkg::pkt_t             pkt,
	output logic                       res_valid,
	input  logic                       res_ready,
	output prrb_pkg::res_t             res,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [prrb_pkg::WIN_W-1:0] cfg_data
);

	prrb_pkg::cmd_t  cmd;
	prrb_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	prrb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.pkt_valid(pkt_valid),
		.pkt_ready(pkt_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	prrb_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.pkt      (pkt),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.stat     (stat),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

endmodule

// ----- design/prrb_ram.sv -----
module prrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- design/prrb_ctrl.sv -----
module prrb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pkt_valid,
	output logic            pkt_ready,
	input  prrb_pkg::stat_t stat,
	output prrb_pkg::cmd_t  cmd
);

	prrb_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prrb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			prrb_pkg::S_IDLE: begin
				if (pkt_valid) state_d = prrb_pkg::S_EVAL;
			end
			prrb_pkg::S_EVAL: begin
				if (stat.in_order) state_d = prrb_pkg::S_SCAN;
				else if (stat.out_free) state_d = prrb_pkg::S_IDLE;
			end
			prrb_pkg::S_SCAN: begin
				if (!stat.scan_more) state_d = prrb_pkg::S_FIRST;
			end
			prrb_pkg::S_FIRST: begin
				if (stat.out_free) begin
					state_d = stat.cnt_zero ? prrb_pkg::S_IDLE : prrb_pkg::S_DRAIN;
				end
			end
			prrb_pkg::S_DRAIN: begin
				if (stat.out_free && stat.cnt_one) state_d = prrb_pkg::S_IDLE;
			end
			default: state_d = prrb_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		pkt_ready = 1'b0;
		unique case (state_q)
			prrb_pkg::S_IDLE: begin
				pkt_ready   = 1'b1;
				cmd.capture = pkt_valid;
			end
			prrb_pkg::S_EVAL: begin
				cmd.scan_init = stat.in_order;
				cmd.eval_load = !stat.in_order && stat.out_free;
			end
			prrb_pkg::S_SCAN: begin
				cmd.scan_step = stat.scan_more;
				cmd.scan_done = !stat.scan_more;
			end
			prrb_pkg::S_FIRST: begin
				cmd.first_load = stat.out_free;
			end
			prrb_pkg::S_DRAIN: begin
				cmd.drain_load = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ----- design/prrb_dp.sv -----
module prrb_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  prrb_pkg::pkt_t                 pkt,
	input  logic                           cfg_valid,
	input  logic [prrb_pkg::WIN_W-1:0]     cfg_data,
	input  prrb_pkg::cmd_t                 cmd,
	output prrb_pkg::stat_t                stat,
	output logic                           res_valid,
	input  logic                           res_ready,
	output prrb_pkg::res_t                 res
);

	prrb_pkg::pkt_t                   pkt_q;
	logic [31:0]                      exp_q;
	logic [31:0]                      walk_q;
	logic [prrb_pkg::CNT_W-1:0]       cnt_q;
	logic [prrb_pkg::WIN_W-1:0]       win_q;
	logic [prrb_pkg::BUF_DEPTH-1:0]   valid_q;
	prrb_pkg::res_t                   res_q;
	logic                             res_valid_q;

	logic [prrb_pkg::WIN_W-1:0]       win;
	logic                             over;
	logic [31:0]                      exp_syn;
	logic                             is_dup;
	logic                             is_store;
	logic [1:0]                       st_single;
	logic                             ram_we;
	logic [prrb_pkg::IDX_W-1:0]       waddr;
	logic [prrb_pkg::IDX_W-1:0]       raddr;
	prrb_pkg::slot_t                  wslot;
	prrb_pkg::slot_t                  rslot;
	logic [$bits(prrb_pkg::slot_t)-1:0] rbits;
	logic [prrb_pkg::IDX_W-1:0]       walk_idx;
	logic                             out_free;

	assign win = (win_q > prrb_pkg::WIN_W'(prrb_pkg::BUF_DEPTH))
		? prrb_pkg::WIN_W'(prrb_pkg::BUF_DEPTH) : win_q;

	// 33-bit compare, no wrap of expected + window
	assign over = {1'b0, pkt_q.seq} > ({1'b0, exp_q} + 33'(win));

	assign exp_syn = (pkt_q.syn_flag && exp_q <= pkt_q.seq) ? pkt_q.seq + 32'd1 : exp_q;
	assign is_dup   = pkt_q.seq < exp_syn;
	assign is_store = pkt_q.seq > exp_syn;

	always_comb begin
		if (over) st_single = prrb_pkg::RS_DROPPED;
		else if (!pkt_q.data_flag) st_single = prrb_pkg::RS_ACCEPTED;
		else if (is_dup) st_single = prrb_pkg::RS_DUPLICATE;
		else st_single = prrb_pkg::RS_BUFFERED;
	end

	assign out_free = !res_valid_q || res_ready;
	assign walk_idx = prrb_pkg::slot_idx(walk_q);

	assign rslot = prrb_pkg::slot_t'(rbits);

	assign stat.in_order  = !over && pkt_q.data_flag && !is_dup && !is_store;
	assign stat.out_free  = out_free;
	assign stat.scan_more = valid_q[walk_idx] && rslot.seq == walk_q
		&& cnt_q != prrb_pkg::CNT_W'(prrb_pkg::BUF_DEPTH);
	assign stat.cnt_zero  = cnt_q == '0;
	assign stat.cnt_one   = cnt_q == prrb_pkg::CNT_W'(1);

	// read address runs one step ahead so rdata matches walk_q next cycle
	always_comb begin
		if (cmd.scan_init) raddr = prrb_pkg::slot_idx(pkt_q.seq + 32'd1);
		else if (cmd.scan_step || cmd.drain_load) raddr = prrb_pkg::slot_idx(walk_q + 32'd1);
		else raddr = walk_idx;
	end

	assign ram_we = cmd.eval_load && !over && pkt_q.data_flag && is_store;
	assign waddr  = prrb_pkg::slot_idx(pkt_q.seq);
	assign wslot  = '{seq: pkt_q.seq, has_data: pkt_q.has_data, payload: pkt_q.payload};

	prrb_ram #(
		.WIDTH($bits(prrb_pkg::slot_t)),
		.DEPTH(prrb_pkg::BUF_DEPTH)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(wslot),
		.raddr(raddr),
		.rdata(rbits)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) pkt_q <= pkt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= prrb_pkg::WIN_RESET;
		end else if (cfg_valid) begin
			win_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q   <= '0;
			valid_q <= '0;
		end else begin
			if (cmd.eval_load && !over) exp_q <= exp_syn;
			if (cmd.scan_done) exp_q <= walk_q;
			if (ram_we) valid_q[waddr] <= 1'b1;
			if (cmd.drain_load) valid_q[walk_idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			walk_q <= pkt_q.seq + 32'd1;
			cnt_q  <= '0;
		end else if (cmd.scan_step) begin
			walk_q <= walk_q + 32'd1;
			cnt_q  <= cnt_q + prrb_pkg::CNT_W'(1);
		end else if (cmd.scan_done) begin
			walk_q <= pkt_q.seq + 32'd1;
		end else if (cmd.drain_load) begin
			walk_q <= walk_q + 32'd1;
			cnt_q  <= cnt_q - prrb_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.eval_load || cmd.first_load || cmd.drain_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval_load) begin
			res_q.status        <= st_single;
			res_q.deliver_valid <= 1'b0;
			res_q.deliver_seq   <= '0;
			res_q.payload_out   <= '0;
			res_q.ack_send      <= !over && (pkt_q.syn_flag || pkt_q.data_flag);
			res_q.ack_number    <= over ? exp_q : exp_syn;
			res_q.last          <= 1'b1;
		end else if (cmd.first_load) begin
			res_q.status        <= prrb_pkg::RS_ACCEPTED;
			res_q.deliver_valid <= pkt_q.has_data;
			res_q.deliver_seq   <= pkt_q.seq;
			res_q.payload_out   <= pkt_q.has_data ? pkt_q.payload : '0;
			res_q.ack_send      <= 1'b1;
			res_q.ack_number    <= exp_q;
			res_q.last          <= cnt_q == '0;
		end else if (cmd.drain_load) begin
			res_q.status        <= prrb_pkg::RS_ACCEPTED;
			res_q.deliver_valid <= rslot.has_data;
			res_q.deliver_seq   <= rslot.seq;
			res_q.payload_out   <= rslot.has_data ? rslot.payload : '0;
			res_q.ack_send      <= 1'b1;
			res_q.ack_number    <= exp_q;
			res_q.last          <= cnt_q == prrb_pkg::CNT_W'(1);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ----- tb/packet_receive_reorder_buffer_unit_tb.sv -----
`timescale 1ns / 100ps

// Tracks the receive state that each accepted packet leaves behind and keeps
// the results each packet should cause, oldest first.
class packet_order_tracker;
	logic [31:0]                 next_seq;
	logic [prrb_pkg::WIN_W-1:0]  window;
	bit                          held         [prrb_pkg::BUF_DEPTH];
	logic [31:0]                 held_seq     [prrb_pkg::BUF_DEPTH];
	bit                          held_data    [prrb_pkg::BUF_DEPTH];
	logic [31:0]                 held_payload [prrb_pkg::BUF_DEPTH];
	prrb_pkg::res_t              due_results[$];
	int                          errors;

	function new();
		next_seq = '0;
		window = prrb_pkg::WIN_RESET;
		errors = 0;
		foreach (held[i])
			held[i] = 1'b0;
	endfunction

	function int open_window();
		return (window > prrb_pkg::BUF_DEPTH) ? prrb_pkg::BUF_DEPTH : int'(window);
	endfunction

	function prrb_pkg::res_t retire(bit with_data, logic [31:0] num, logic [31:0] handle);
		prrb_pkg::res_t r;
		r = '0;
		r.status = prrb_pkg::RS_ACCEPTED;
		r.deliver_valid = with_data;
		r.deliver_seq = num;
		r.payload_out = with_data ? handle : 32'd0;
		return r;
	endfunction

	function void note_packet(prrb_pkg::pkt_t p);
		prrb_pkg::res_t               outs[$];
		prrb_pkg::res_t               r;
		logic [prrb_pkg::IDX_W-1:0]   s;
		bit                           ack;
		ack = 1'b0;
		r = '0;
		if ({1'b0, p.seq} > {1'b0, next_seq} + 33'(open_window())) begin
			r.status = prrb_pkg::RS_DROPPED;
			outs = {outs, r};
		end else begin
			if (p.syn_flag) begin
				ack = 1'b1;
				if (next_seq <= p.seq)
					next_seq = p.seq + 32'd1;
			end
			if (!p.data_flag) begin
				r.status = prrb_pkg::RS_ACCEPTED;
				outs = {outs, r};
			end else begin
				ack = 1'b1;
				if (p.seq < next_seq) begin
					r.status = prrb_pkg::RS_DUPLICATE;
					outs = {outs, r};
				end else if (p.seq > next_seq) begin
					s = prrb_pkg::IDX_W'(p.seq % prrb_pkg::BUF_DEPTH);
					held[s] = 1'b1;
					held_seq[s] = p.seq;
					held_data[s] = p.has_data;
					held_payload[s] = p.payload;
					r.status = prrb_pkg::RS_BUFFERED;
					outs = {outs, r};
				end else begin
					next_seq = p.seq + 32'd1;
					outs = {outs, retire(p.has_data, p.seq, p.payload)};
					// a slot holding some other number ends the walk but stays put
					for (int k = 0; k < prrb_pkg::BUF_DEPTH; k++) begin
						s = prrb_pkg::IDX_W'(next_seq % prrb_pkg::BUF_DEPTH);
						if (!held[s] || held_seq[s] != next_seq)
							break;
						outs = {outs, retire(held_data[s], held_seq[s], held_payload[s])};
						held[s] = 1'b0;
						next_seq = next_seq + 32'd1;
					end
				end
			end
		end
		foreach (outs[k]) begin
			outs[k].ack_send = ack;
			outs[k].ack_number = next_seq;
			outs[k].last = (k == outs.size() - 1);
			due_results = {due_results, outs[k]};
		end
	endfunction

	function void report(string what, prrb_pkg::res_t want, prrb_pkg::res_t got);
		errors++;
		if (errors <= 10)
			$display("ERROR %s (exp/act): status %0d/%0d dv %0b/%0b dseq %h/%h pay %h/%h",
				what, want.status, got.status, want.deliver_valid, got.deliver_valid,
				want.deliver_seq, got.deliver_seq, want.payload_out, got.payload_out,
				"  ack %0b/%0b num %h/%h last %0b/%0b", want.ack_send, got.ack_send,
				want.ack_number, got.ack_number, want.last, got.last);
	endfunction

	function void check_result(prrb_pkg::res_t got);
		prrb_pkg::res_t want;
		if (due_results.size() == 0) begin
			report("result with nothing due", '0, got);
			return;
		end
		want = due_results[0];
		due_results.delete(0);
		if (got.status !== want.status || got.deliver_valid !== want.deliver_valid ||
				got.deliver_seq !== want.deliver_seq || got.payload_out !== want.payload_out ||
				got.ack_send !== want.ack_send || got.ack_number !== want.ack_number ||
				got.last !== want.last)
			report("result mismatch", want, got);
	endfunction
endclass

module packet_receive_reorder_buffer_unit_tb;

	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 3000;

	logic                       clk;
	logic                       arst_n;
	logic                       pkt_valid;
	logic                       pkt_ready;
	prrb_pkg::pkt_t             pkt;
	logic                       res_valid;
	logic                       res_ready;
	prrb_pkg::res_t             res;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [prrb_pkg::WIN_W-1:0] cfg_data;

	packet_order_tracker tracker;
	bit                  hold_req;
	bit                  use_gaps;
	int                  burst_left;
	int                  sent;

	packet_receive_reorder_buffer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_ready (pkt_ready),
		.pkt       (pkt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic prrb_pkg::pkt_t make_pkt(logic [31:0] num, bit syn, bit dat, bit hd,
			logic [31:0] handle);
		prrb_pkg::pkt_t p;
		p.seq = num;
		p.syn_flag = syn;
		p.data_flag = dat;
		p.has_data = hd;
		p.payload = handle;
		return p;
	endfunction

	// valid stays up across a burst; with gaps on, it drops between bursts
	task automatic send_packet(prrb_pkg::pkt_t p);
		pkt <= p;
		pkt_valid <= 1'b1;
		do @(posedge clk); while (!pkt_ready);
		tracker.note_packet(p);
		sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			if (use_gaps) begin
				pkt_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	task automatic wait_for_results();
		pkt_valid <= 1'b0;
		while (tracker.due_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_window(logic [prrb_pkg::WIN_W-1:0] w);
		cfg_data <= w;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracker.window = w;
	endtask

	// numbers expected .. expected+n-1, shuffled or highest first
	task automatic send_in_order_run(int n, bit reversed);
		logic [31:0] base;
		int          order[$];
		int          j;
		int          t;
		base = tracker.next_seq;
		for (int k = 0; k < n; k++)
			order = {order, (reversed ? n - 1 - k : k)};
		if (!reversed) begin
			for (int k = n - 1; k > 0; k--) begin
				j = $urandom_range(0, k);
				t = order[k];
				order[k] = order[j];
				order[j] = t;
			end
		end
		foreach (order[k])
			send_packet(make_pkt(base + order[k], 1'b0, 1'b1, $urandom_range(0, 4) != 0,
				$urandom()));
	endtask

	task automatic send_noise();
		int w;
		w = tracker.open_window();
		case ($urandom_range(0, 4))
			0: send_packet(make_pkt(tracker.next_seq + $urandom_range(0, w), 1'b1,
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom()));
			1: send_packet(make_pkt(tracker.next_seq + $urandom_range(0, w), 1'b0, 1'b0,
				1'($urandom_range(0, 1)), $urandom()));
			2: send_packet(make_pkt(tracker.next_seq - $urandom_range(1, 40), 1'b0, 1'b1,
				1'($urandom_range(0, 1)), $urandom()));
			3: send_packet(make_pkt(tracker.next_seq + w + 1 + $urandom_range(0, 300),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), $urandom()));
			default: send_packet(make_pkt($urandom(), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom()));
		endcase
	endtask

	task automatic run_phase(int count);
		int target;
		int max_n;
		int n;
		target = sent + count;
		while (sent < target) begin
			if ($urandom_range(0, 99) < 65) begin
				max_n = tracker.open_window() + 1;
				if ($urandom_range(0, 9) == 0)
					n = $urandom_range(1, max_n);
				else
					n = $urandom_range(1, (max_n < 8) ? max_n : 8);
				send_in_order_run(n, 1'b0);
			end else begin
				send_noise();
			end
		end
	endtask

	initial begin : stimulus
		tracker = new;
		arst_n <= 1'b0;
		pkt_valid <= 1'b0;
		pkt <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		hold_req = 1'b0;
		use_gaps = 1'b1;
		burst_left = 1;
		sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// window still at its reset value here
		send_packet(make_pkt(32'd0, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF));
		send_packet(make_pkt(32'd0, 1'b0, 1'b1, 1'b1, 32'h1234_5678));
		send_packet(make_pkt(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 32'd0));
		send_packet(make_pkt(32'd33, 1'b0, 1'b1, 1'b1, 32'hA5A5_0033));
		send_packet(make_pkt(32'd34, 1'b0, 1'b1, 1'b1, 32'h5A5A_0034));
		send_packet(make_pkt(32'd3, 1'b0, 1'b1, 1'b0, 32'hDEAD_0003));
		send_packet(make_pkt(32'd2, 1'b0, 1'b1, 1'b1, 32'hBEEF_0002));
		send_packet(make_pkt(32'd10, 1'b0, 1'b0, 1'b1, 32'h0000_0010));
		send_packet(make_pkt(32'd5, 1'b1, 1'b0, 1'b0, 32'h0000_0005));
		send_packet(make_pkt(32'd7, 1'b1, 1'b1, 1'b1, 32'h0000_0007));
		send_packet(make_pkt(32'd3, 1'b1, 1'b0, 1'b0, 32'h0000_0003));
		// store 10, then SYN lands on it: no drain, slot 10 goes stale
		send_packet(make_pkt(32'd10, 1'b0, 1'b1, 1'b1, 32'h1010_1010));
		send_packet(make_pkt(32'd9, 1'b1, 1'b0, 1'b0, 32'h0));
		send_packet(make_pkt(32'd10, 1'b0, 1'b1, 1'b1, 32'h2020_2020));
		send_packet(make_pkt(32'd40, 1'b1, 1'b0, 1'b0, 32'h0));
		send_packet(make_pkt(32'd41, 1'b0, 1'b1, 1'b1, 32'h4141_4141));
		// 74 overwrites the stale entry in slot 10 and is drained after 73
		send_packet(make_pkt(32'd74, 1'b0, 1'b1, 1'b1, 32'h7474_7474));
		send_packet(make_pkt(32'd72, 1'b1, 1'b0, 1'b0, 32'h0));
		send_packet(make_pkt(32'd73, 1'b0, 1'b1, 1'b1, 32'h7373_7373));

		wait_for_results();
		write_window('0);
		send_packet(make_pkt(tracker.next_seq + 32'd1, 1'b0, 1'b1, 1'b1, $urandom()));
		send_packet(make_pkt(tracker.next_seq, 1'b0, 1'b1, 1'b1, $urandom()));
		wait_for_results();
		write_window('1);
		send_packet(make_pkt(tracker.next_seq + 32'd32, 1'b0, 1'b1, 1'b1, $urandom()));
		send_packet(make_pkt(tracker.next_seq + 32'd33, 1'b0, 1'b1, 1'b1, $urandom()));

		for (int ph = 0; ph < 7; ph++) begin
			wait_for_results();
			case (ph)
				0: write_window(prrb_pkg::WIN_W'(32));
				1: write_window(prrb_pkg::WIN_W'(1));
				2: write_window('0);
				3: write_window('1);
				default: write_window(prrb_pkg::WIN_W'($urandom_range(0, 63)));
			endcase
			use_gaps = (ph % 2) != 0;
			if (ph == 0) begin
				// receiver holds off while the sender keeps pushing
				hold_req = 1'b1;
				send_in_order_run(prrb_pkg::BUF_DEPTH + 1, 1'b1);
			end
			run_phase(48);
		end

		wait_for_results();
		repeat (30) @(posedge clk);
		if (tracker.errors == 0 && tracker.due_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin : result_sink
		int mode;
		int tick;
		res_ready <= 1'b0;
		mode = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && res_ready)
				tracker.check_result(res);
			if (hold_req) begin
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				tick++;
				if (tick % 40 == 0)
					mode = $urandom_range(0, 3);
				case (mode)
					0: res_ready <= 1'b1;
					1: res_ready <= 1'($urandom_range(0, 1));
					2: res_ready <= (tick % 5) == 0;
					default: res_ready <= $urandom_range(0, 7) != 0;
				endcase
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((pkt_valid && pkt_ready) || (res_valid && res_ready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/prrb_pkg.sv
design/prrb_ram.sv
design/prrb_ctrl.sv
design/prrb_dp.sv
design/packet_receive_reorder_buffer_unit.sv
tb/packet_receive_reorder_buffer_unit_tb.sv
